/* hw/rtl/clps_pkg.sv */
// package for the charlieplexed led pwm scanner
// holds slot constants, pin tables, the sequencer state type and the memory request type
// no dependencies
`timescale 1ns / 1ps

package clps_pkg;

    localparam int NUM_SLOTS = 13;
    localparam int SLOT_W    = 4;
    localparam int VAL_W     = 8;
    localparam int TICK_W    = 9;
    localparam int PIN_W     = 4;

    localparam logic [SLOT_W-1:0] DARK_SLOT = 4'd12;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef logic [1:0] pin_idx_t;

    localparam pin_idx_t ANODE_PIN [NUM_SLOTS] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0
    };
    localparam pin_idx_t CATHODE_PIN [NUM_SLOTS] = '{
        2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_MUL,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [SLOT_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [PIN_W-1:0] drive;
        logic [PIN_W-1:0] high;
    } pins_t;

    // next slot in scan order, dark slot wraps to the first led
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] n;
        begin
            n = (s < DARK_SLOT) ? s + 4'd1 : 4'd0;
            return n;
        end
    endfunction

endpackage

/* hw/rtl/clps_ifs.sv */
// valid/ready channel interfaces for command words and status words
// depends on clps_pkg
`timescale 1ns / 1ps

interface clps_cmd_if;
    import clps_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SLOT_W-1:0] led_index;
    logic [VAL_W-1:0]  led_value;

    modport source (output valid, kind, led_index, led_value, input ready);
    modport sink   (input valid, kind, led_index, led_value, output ready);
endinterface

interface clps_status_if;
    import clps_pkg::*;

    logic              valid;
    logic              ready;
    logic [PIN_W-1:0]  pin_drive;
    logic [PIN_W-1:0]  pin_high;
    logic [SLOT_W-1:0] active_slot;
    logic              slot_changed;

    modport source (output valid, pin_drive, pin_high, active_slot, slot_changed, input ready);
    modport sink   (input valid, pin_drive, pin_high, active_slot, slot_changed, output ready);
endinterface

/* hw/rtl/clps_bright_mem.sv */
// brightness table: 13-entry synchronous memory, one write and one registered read port
// per-entry valid bits make unwritten entries read as zero after reset; depends on clps_pkg
`timescale 1ns / 1ps

module clps_bright_mem (
    input  logic                              clk,
    input  logic                              rst_n,
    input  clps_pkg::mem_req_t                req,
    output logic [clps_pkg::VAL_W-1:0]        rdata
);
    import clps_pkg::*;

    logic [VAL_W-1:0]     mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] vld_reg;
    logic [VAL_W-1:0]     mem_q;
    logic                 vld_q;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        mem_q <= mem[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            vld_q   <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                vld_reg[req.waddr] <= 1'b1;
            end
            vld_q <= vld_reg[req.raddr];
        end
    end

    // entry never written since reset reads as zero
    assign rdata = vld_q ? mem_q : '0;

endmodule

/* hw/rtl/clps_pin_decode.sv */
// maps the selected slot to charlieplex pin drive and level
// depends on clps_pkg
`timescale 1ns / 1ps

module clps_pin_decode (
    input  logic [clps_pkg::SLOT_W-1:0] slot,
    input  logic                        lit,
    output clps_pkg::pins_t             pins
);
    import clps_pkg::*;

    logic [SLOT_W-1:0] s;
    logic [PIN_W-1:0]  a_bit;
    logic [PIN_W-1:0]  c_bit;

    always_comb
    begin
        s     = (slot < 4'(NUM_SLOTS)) ? slot : 4'd0;
        a_bit = PIN_W'(1) << ANODE_PIN[s];
        c_bit = PIN_W'(1) << CATHODE_PIN[s];
        if (lit)
        begin
            pins.drive = a_bit | c_bit;
            pins.high  = a_bit & ~c_bit;
        end
        else
        begin
            pins.drive = '0;
            pins.high  = '0;
        end
    end

endmodule

/* hw/rtl/charlieplex_led_pwm_scanner.sv */
// top level of the charlieplexed led pwm scanner: sequencer, slot timer and status register
// depends on clps_pkg, clps_ifs, clps_bright_mem and clps_pin_decode
`timescale 1ns / 1ps

// Twelve charlieplexed leds on four pins plus a dark filler slot (slot 12), lit one at
// a time. Command words either write one brightness entry (kind 0, index above 12 is
// ignored) or deliver one prescaled timer tick (kind 1). Every command word returns
// exactly one status word with the current pin drive/level, the selected slot and a
// flag set when that tick expired the slot time. On expiry the scan walks forward from
// the current slot to the next one whose brightness is nonzero (the dark slot is always
// taken) and loads ((v*v)>>8)+1 ticks. The brightness table sits in a 13-entry memory
// with one registered read port; the walk reads one entry per cycle. A write word or a
// tick that does not expire goes from EXEC to RESP and the status register; an expiring
// tick also walks (SCAN, reading 1 to 13 table entries) and loads the slot time (MUL)
// before RESP. The status word sits in an output register, so the next command word can
// be taken while the previous status word waits. The user must write scan_enable through
// cfg_we/cfg_wdata only while the block is idle; the block itself does not enforce this.
// Setting scan_enable lights the current slot at once, clearing it floats all pins and
// freezes the timer and slot. Reset clears the table at once (no clearing pass).

module charlieplex_led_pwm_scanner (
    input  logic                clk,
    input  logic                rst_n,
    clps_cmd_if.sink            cmd,
    clps_status_if.source       status,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);
    import clps_pkg::*;

    // sequencer state
    state_t state_reg, state_next;

    // scan state
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [TICK_W-1:0] ticks_reg,    ticks_next;
    logic              lit_yet_reg,  lit_yet_next;
    logic              scan_en_reg;

    // captured command word
    logic              kind_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [VAL_W-1:0]  val_reg;

    // walk candidate and found brightness
    logic [SLOT_W-1:0] cand_reg, cand_next;
    logic [VAL_W-1:0]  bval_reg, bval_next;
    logic              changed_reg, changed_next;

    // status output register
    logic              out_valid_reg, out_valid_next;
    logic [PIN_W-1:0]  out_drive_reg;
    logic [PIN_W-1:0]  out_high_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_chg_reg;

    mem_req_t          mem_req;
    logic [VAL_W-1:0]  mem_rdata;
    pins_t             pins;
    logic              out_load;
    logic              tick_expires;
    logic              entry_hit;
    logic [2*VAL_W-1:0] sq;

    clps_bright_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    clps_pin_decode u_pins (
        .slot (cur_slot_reg),
        .lit  (scan_en_reg & lit_yet_reg),
        .pins (pins)
    );

    assign tick_expires = (ticks_reg <= TICK_W'(1));
    // the dark slot ends the walk whatever its table value
    assign entry_hit    = (mem_rdata != '0) || (cand_reg == DARK_SLOT);
    assign sq           = bval_reg * bval_reg;

    // status register loads once the previous word is gone or leaving
    assign out_load = (state_reg == ST_RESP) && (!out_valid_reg || status.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (kind_reg == KIND_TICK && scan_en_reg && tick_expires)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (entry_hit)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cur_slot_next = cur_slot_reg;
        ticks_next    = ticks_reg;
        lit_yet_next  = lit_yet_reg;
        cand_next     = cand_reg;
        bval_next     = bval_reg;
        changed_next  = changed_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg;
        mem_req.wdata = val_reg;
        mem_req.raddr = cand_reg;
        cmd.ready     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            ST_EXEC:
            begin
                changed_next = 1'b0;
                if (kind_reg == KIND_WRITE)
                begin
                    mem_req.we = (idx_reg <= DARK_SLOT);
                end
                else if (scan_en_reg)
                begin
                    if (tick_expires)
                    begin
                        // start the walk at the slot after the current one
                        cand_next     = next_slot(cur_slot_reg);
                        mem_req.raddr = next_slot(cur_slot_reg);
                    end
                    else
                    begin
                        ticks_next = ticks_reg - TICK_W'(1);
                    end
                end
            end
            ST_SCAN:
            begin
                if (entry_hit)
                begin
                    cur_slot_next = cand_reg;
                    bval_next     = mem_rdata;
                end
                else
                begin
                    // read of the following entry overlaps the check of this one
                    cand_next     = next_slot(cand_reg);
                    mem_req.raddr = next_slot(cand_reg);
                end
            end
            ST_MUL:
            begin
                ticks_next   = {1'b0, sq[2*VAL_W-1:VAL_W]} + TICK_W'(1);
                lit_yet_next = 1'b1;
                changed_next = 1'b1;
            end
            ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase

        // enabling lights the current slot right away
        if (cfg_we && cfg_wdata)
        begin
            lit_yet_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_slot_reg  <= '0;
            ticks_reg     <= '0;
            lit_yet_reg   <= 1'b0;
            scan_en_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            changed_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_slot_reg  <= cur_slot_next;
            ticks_reg     <= ticks_next;
            lit_yet_reg   <= lit_yet_next;
            out_valid_reg <= out_valid_next;
            changed_reg   <= changed_next;
            if (cfg_we)
            begin
                scan_en_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            kind_reg <= cmd.kind;
            idx_reg  <= cmd.led_index;
            val_reg  <= cmd.led_value;
        end
        cand_reg <= cand_next;
        bval_reg <= bval_next;
        if (out_load)
        begin
            out_drive_reg <= pins.drive;
            out_high_reg  <= pins.high;
            out_slot_reg  <= cur_slot_reg;
            out_chg_reg   <= changed_reg;
        end
    end

    assign status.valid        = out_valid_reg;
    assign status.pin_drive    = out_drive_reg;
    assign status.pin_high     = out_high_reg;
    assign status.active_slot  = out_slot_reg;
    assign status.slot_changed = out_chg_reg;

    // selected slot never leaves the table range
    assert property (@(posedge clk) disable iff (!rst_n) cur_slot_reg <= DARK_SLOT)
        else $error("current slot out of range");

    // a slot advance always comes with lit pins
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && changed_reg |-> pins.drive != '0)
        else $error("slot advanced with pins floating");

    // the walk leaves only toward the tick load
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |=> state_reg == ST_SCAN || state_reg == ST_MUL)
        else $error("walk left to an unexpected state");

    // no command word is taken while a word is still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |-> !cmd.ready)
        else $error("command taken while busy");

endmodule

/* tb/sv/charlieplex_led_pwm_scanner_tb.sv */
// self-checking testbench for the charlieplexed led pwm scanner
// drives command words and checks status words against a local scan predictor
// depends on clps_pkg, clps_ifs and charlieplex_led_pwm_scanner
`timescale 1ns / 1ps

module charlieplex_led_pwm_scanner_tb;
    import clps_pkg::*;

    // run shape
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_WORDS  = 212;
    localparam int SETTLE_CYC   = 24;    // margin beyond the longest expiring tick
    localparam int STALL_LIMIT  = 5000;  // cycles with no word moving on either side
    localparam int HOLD_AFTER   = 500;   // status words seen before the long hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    localparam logic SCAN_OFF = 1'b0;
    localparam logic SCAN_ON  = 1'b1;

    // led wiring: anode and cathode pin per slot, dark slot has both on pin 0
    localparam logic [1:0] SRC_PIN [0:12] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0
    };
    localparam logic [1:0] SNK_PIN [0:12] = '{
        2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd0
    };

    typedef struct packed {
        logic [PIN_W-1:0]  drive;
        logic [PIN_W-1:0]  high;
        logic [SLOT_W-1:0] slot;
        logic              changed;
    } status_word_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_op_t;
    typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_SHUT} sink_mode_t;

    // one directed step: either a command word or a scan_enable write;
    // typed rows carry the status word read straight off the spec
    typedef struct {
        row_op_t           op;
        logic              en;
        logic              kind;
        logic [SLOT_W-1:0] idx;
        logic [VAL_W-1:0]  val;
        bit                typed;
        logic [PIN_W-1:0]  w_drive;
        logic [PIN_W-1:0]  w_high;
        logic [SLOT_W-1:0] w_slot;
        logic              w_chg;
    } row_t;

    localparam int PLAN_LEN = 21;

    row_t plan [PLAN_LEN] = '{
        // disabled after reset: tick with a zero count does nothing, pins float
        '{ROW_WORD, SCAN_OFF, KIND_TICK,  4'd0,  8'd0,   1'b1, 4'h0, 4'h0, 4'd0,  1'b0},
        // writes above slot 12 are dropped
        '{ROW_WORD, SCAN_OFF, KIND_WRITE, 4'd15, 8'd255, 1'b1, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_WRITE, 4'd13, 8'd170, 1'b1, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_WRITE, 4'd0,  8'd255, 1'b1, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_WRITE, 4'd12, 8'd255, 1'b1, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_WRITE, 4'd11, 8'd1,   1'b1, 4'h0, 4'h0, 4'd0,  1'b0},
        // enabling lights slot 0 at once: pin 0 high, pin 1 low
        '{ROW_CFG,  SCAN_ON,  KIND_TICK,  4'd0,  8'd0,   1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_WRITE, 4'd5,  8'd16,  1'b1, 4'h3, 4'h1, 4'd0,  1'b0},
        // zero count expires, walk skips empty slots to 5, then 11, then dark
        '{ROW_WORD, SCAN_OFF, KIND_TICK,  4'd0,  8'd0,   1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_TICK,  4'd15, 8'd255, 1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_TICK,  4'd0,  8'd0,   1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_TICK,  4'd0,  8'd0,   1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_WRITE, 4'd12, 8'd0,   1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_TICK,  4'd0,  8'd0,   1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        // disabling floats pins but keeps reporting the dark slot
        '{ROW_CFG,  SCAN_OFF, KIND_TICK,  4'd0,  8'd0,   1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_TICK,  4'd0,  8'd0,   1'b1, 4'h0, 4'h0, 4'd12, 1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_WRITE, 4'd0,  8'd0,   1'b1, 4'h0, 4'h0, 4'd12, 1'b0},
        '{ROW_CFG,  SCAN_ON,  KIND_TICK,  4'd0,  8'd0,   1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_TICK,  4'd0,  8'd0,   1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_WRITE, 4'd3,  8'd255, 1'b0, 4'h0, 4'h0, 4'd0,  1'b0},
        '{ROW_WORD, SCAN_OFF, KIND_WRITE, 4'd7,  8'd85,  1'b0, 4'h0, 4'h0, 4'd0,  1'b0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    clps_cmd_if    cmd_ch ();
    clps_status_if sts_ch ();

    charlieplex_led_pwm_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .status    (sts_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state, mirrors the block after reset
    logic [VAL_W-1:0]  lvl_tbl [NUM_SLOTS] = '{default: '0};
    logic [SLOT_W-1:0] cur_slot   = '0;
    logic [8:0]        ticks_left = '0;
    logic              lit        = 1'b0;
    logic              scan_on    = 1'b0;

    // status words still owed by the block, oldest first
    status_word_t owed_q [$];

    int burst_left    = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int bad_words     = 0;
    int advances      = 0;
    int dark_entries  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // apply one command word to the predicted scan and return its status word
    function automatic status_word_t scan_step(input logic kind, input logic [SLOT_W-1:0] idx,
                                               input logic [VAL_W-1:0] val);
        status_word_t      r;
        logic [SLOT_W-1:0] s;
        logic [15:0]       sq;
        logic [PIN_W-1:0]  a_bit;
        logic [PIN_W-1:0]  c_bit;
        int                n;
        r = '0;
        if (kind == KIND_WRITE)
        begin
            if (idx < NUM_SLOTS)
                lvl_tbl[idx] = val;
        end
        else if (scan_on)
        begin
            if (ticks_left <= 9'd1)
            begin
                // walk forward to the next lit slot, dark slot always stops the walk
                s = cur_slot;
                for (n = 0; n < NUM_SLOTS; n++)
                begin
                    s = (s < DARK_SLOT) ? s + 4'd1 : 4'd0;
                    if (lvl_tbl[s] != '0 || s == DARK_SLOT)
                        break;
                end
                cur_slot   = s;
                sq         = 16'(lvl_tbl[s]) * 16'(lvl_tbl[s]);
                ticks_left = 9'(sq[15:8]) + 9'd1;
                lit        = 1'b1;
                r.changed  = 1'b1;
            end
            else
            begin
                ticks_left = ticks_left - 9'd1;
            end
        end
        if (scan_on && lit)
        begin
            a_bit   = 4'b0001 << SRC_PIN[cur_slot];
            c_bit   = 4'b0001 << SNK_PIN[cur_slot];
            r.drive = a_bit | c_bit;
            r.high  = a_bit & ~c_bit;
        end
        r.slot = cur_slot;
        return r;
    endfunction

    // offer one command word, in bursts with random gaps between them
    task automatic send_word(input logic kind, input logic [SLOT_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input bit typed,
                             input status_word_t want);
        int           gap;
        status_word_t pred;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) < 3)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(10, 30);
            else
                gap = $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.kind      <= kind;
        cmd_ch.led_index <= idx;
        cmd_ch.led_value <= val;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        // word taken at this edge
        burst_left--;
        words_sent++;
        pred = scan_step(kind, idx, val);
        owed_q.push_back(typed ? want : pred);
    endtask

    // drain the block, then write scan_enable while it is idle
    task automatic set_scan(input logic en);
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (owed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(posedge clk);
        cfg_we  <= 1'b0;
        scan_on = en;
        if (en)
            lit = 1'b1;
    endtask

    // stimulus: directed plan, then random phases under changing scan_enable
    initial
    begin : stimulus
        status_word_t      want;
        logic              k;
        logic [SLOT_W-1:0] ix;
        logic [VAL_W-1:0]  v;
        int                p;
        int                i;
        int                zero_pct;
        int                pick;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.kind      = KIND_WRITE;
        cmd_ch.led_index = '0;
        cmd_ch.led_value = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            if (plan[r].op == ROW_CFG)
            begin
                set_scan(plan[r].en);
            end
            else
            begin
                want.drive   = plan[r].w_drive;
                want.high    = plan[r].w_high;
                want.slot    = plan[r].w_slot;
                want.changed = plan[r].w_chg;
                send_word(plan[r].kind, plan[r].idx, plan[r].val, plan[r].typed, want);
            end
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // phases 2 and 5 run with the scan stopped
            set_scan((p % 3 == 2) ? SCAN_OFF : SCAN_ON);
            // phase 4 mostly clears entries so the walk runs long
            zero_pct = (p == 4) ? 70 : 20;
            for (i = 0; i < PHASE_WORDS; i++)
            begin
                k  = ($urandom_range(0, 99) < 62) ? KIND_TICK : KIND_WRITE;
                ix = 4'($urandom_range(0, 15));
                v  = 8'($urandom_range(0, 255));
                if (k == KIND_WRITE)
                begin
                    if ($urandom_range(0, 99) >= 8)
                        ix = 4'($urandom_range(0, 12));
                    pick = $urandom_range(0, 99);
                    // short slot times dominate so the scan keeps moving
                    if (pick < zero_pct)
                        v = '0;
                    else if (pick < zero_pct + 35)
                        v = 8'($urandom_range(1, 20));
                    else if (pick < zero_pct + 55)
                        v = 8'($urandom_range(21, 90));
                    else if (pick < zero_pct + 63)
                        v = 8'd255;
                end
                send_word(k, ix, v, 1'b0, '0);
            end
        end

        cmd_ch.valid <= 1'b0;
        while (owed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (owed_q.size() != 0)
        begin
            $display("%0d status words never arrived", owed_q.size());
            bad_words = bad_words + owed_q.size();
        end

        $display("%0d command words over %0d scan settings, %0d status words checked",
                 words_sent, NUM_PHASES + 3, words_checked);
        $display("%0d slot advances, %0d dark slot entries, %0d mismatches",
                 advances, dark_entries, bad_words);
        if (bad_words == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // status sink: open, choppy and shut runs, plus one long hold-off to back up the block
    initial
    begin : status_sink
        sink_mode_t mode;
        int         run_left;
        bit         held_off;
        mode         = SINK_OPEN;
        run_left     = 0;
        held_off     = 1'b0;
        sts_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_off && words_checked >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                sts_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode     = sink_mode_t'($urandom_range(0, 2));
                    run_left = (mode == SINK_SHUT) ? $urandom_range(1, 12)
                                                   : $urandom_range(4, 40);
                end
                run_left--;
                case (mode)
                    SINK_OPEN:   sts_ch.ready <= 1'b1;
                    SINK_CHOPPY: sts_ch.ready <= 1'($urandom_range(0, 1));
                    default:     sts_ch.ready <= 1'b0;
                endcase
            end
        end
    end

    // compare every accepted status word with the oldest owed one
    always @(posedge clk)
    begin : status_check
        status_word_t got;
        status_word_t want;
        if (sts_ch.valid && sts_ch.ready)
        begin
            got.drive   = sts_ch.pin_drive;
            got.high    = sts_ch.pin_high;
            got.slot    = sts_ch.active_slot;
            got.changed = sts_ch.slot_changed;
            words_checked++;
            if (got.changed)
            begin
                advances++;
                if (got.slot == DARK_SLOT)
                    dark_entries++;
            end
            if (owed_q.size() == 0)
            begin
                if (bad_words < MAX_REPORTS)
                    $display("%0t: unowed status word: drive=%h high=%h slot=%0d chg=%b",
                             $realtime, got.drive, got.high, got.slot, got.changed);
                bad_words++;
            end
            else
            begin
                want = owed_q.pop_front();
                if (got.drive !== want.drive || got.high !== want.high ||
                    got.slot !== want.slot || got.changed !== want.changed)
                begin
                    if (bad_words < MAX_REPORTS)
                    begin
                        $display("%0t: status mismatch, want drive=%h high=%h slot=%0d chg=%b",
                                 $realtime, want.drive, want.high, want.slot, want.changed);
                        $display("%0t:                   got drive=%h high=%h slot=%0d chg=%b",
                                 $realtime, got.drive, got.high, got.slot, got.changed);
                    end
                    bad_words++;
                end
            end
        end
    end

    // watchdog: ends the run when no word moves on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !(cmd_ch.valid && cmd_ch.ready) && !(sts_ch.valid && sts_ch.ready))
                quiet++;
            else
                quiet = 0;
        end
        $display("watchdog: no word moved for %0d cycles, %0d status words owed",
                 STALL_LIMIT, owed_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
